// ===== design/rwpm_pkg.sv =====
package rwpm_pkg;

  localparam int PIXEL_BITS   = 8;
  localparam int DNUM_W       = PIXEL_BITS + 1;
  localparam int DDEN_W       = PIXEL_BITS + 2;
  localparam int CORDIC_W     = PIXEL_BITS + 34;
  localparam int CORDIC_STEPS = 28;
  localparam int ANGLE_W      = 32;
  localparam int PHASE_W      = 16;
  localparam int MOD_W        = 12;
  localparam int TEST_W       = 2 * PIXEL_BITS + 14;
  localparam int LIM_SHIFT    = 10;
  localparam int X_SHIFT      = 30;
  localparam int RESULT_LATENCY = CORDIC_STEPS + 3;

  localparam logic signed [CORDIC_W-1:0] SQRT3_Q30 = CORDIC_W'(64'sd1859775393);
  localparam logic [ANGLE_W-1:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] ROUND_HALF = 32'h0000_8000;

  localparam logic [ANGLE_W-1:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5
  };

endpackage

// ===== design/rgb_wrapped_phase_modulation.sv =====
// A beat taken with start passes through one input stage, one setup stage,
//   28 CORDIC stages and one output register.
// Throughput: one pixel every cycle; busy is high in reset and the cycle after it.
// Reset (rst, synchronous, active high) drops all beats in flight and clears the
//   threshold to 0. The receiver cannot stall the result strobe.
module rgb_wrapped_phase_modulation
  import rwpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [PIXEL_BITS-1:0] red,
  input  logic [PIXEL_BITS-1:0] green,
  input  logic [PIXEL_BITS-1:0] blue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [MOD_W-1:0]      cfg_data,
  output logic                  done,
  output logic [PHASE_W-1:0]    phase,
  output logic [MOD_W-1:0]      modulation,
  output logic                  phase_ok
);

  logic [MOD_W-1:0] threshold;

  logic signed [DDEN_W-1:0] r_e, g_e, b_e, dden_in;
  logic signed [DNUM_W-1:0] dnum_in;

  logic                     v_in;
  logic                     zero_in;
  logic signed [DNUM_W-1:0] dnum;
  logic signed [DDEN_W-1:0] dden;

  logic                     neg;
  logic signed [DNUM_W:0]   dn_adj;
  logic signed [DDEN_W:0]   dd_adj;
  logic signed [CORDIC_W-1:0] dd_ext, x_init, y_init;

  logic                       cv    [0:CORDIC_STEPS];
  logic                       czero [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cx    [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cy    [0:CORDIC_STEPS];
  logic [ANGLE_W-1:0]         cz    [0:CORDIC_STEPS];

  logic [2*DNUM_W-1:0] nsq;
  logic [2*DDEN_W-1:0] dsq;
  logic [TEST_W-1:0]   lim [1:MOD_W];
  logic [MOD_W-1:0]    mq  [1:CORDIC_STEPS];

  logic [ANGLE_W-1:0]  z_round;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      threshold <= '0;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        threshold <= cfg_data;
      end
    end
  end

  assign r_e     = $signed({2'b00, red});
  assign g_e     = $signed({2'b00, green});
  assign b_e     = $signed({2'b00, blue});
  assign dden_in = (r_e <<< 1) - g_e - b_e;
  assign dnum_in = DNUM_W'(g_e - b_e);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else begin
      v_in <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    dnum    <= dnum_in;
    dden    <= dden_in;
    zero_in <= (red == green) && (green == blue);
  end

  // fold the left half-plane onto the right
  assign neg    = dden[DDEN_W-1];
  assign dn_adj = neg ? -(DNUM_W+1)'(dnum) : (DNUM_W+1)'(dnum);
  assign dd_adj = neg ? -(DDEN_W+1)'(dden) : (DDEN_W+1)'(dden);
  assign dd_ext = CORDIC_W'(dd_adj);
  assign x_init = dd_ext <<< X_SHIFT;
  assign y_init = dn_adj * SQRT3_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    czero[0] <= zero_in;
    cx[0]    <= x_init;
    cy[0]    <= y_init;
    cz[0]    <= neg ? HALF_TURN : '0;
    nsq      <= (2*DNUM_W)'(dnum) * (2*DNUM_W)'(dnum);
    dsq      <= (2*DDEN_W)'(dden) * (2*DDEN_W)'(dden);
  end

  for (genvar c = 0; c < CORDIC_STEPS; c++) begin : g_cordic
    logic signed [CORDIC_W-1:0] dx, dy;

    assign dx = cy[c] >>> c;
    assign dy = cx[c] >>> c;

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[c+1] <= 1'b0;
      end else begin
        cv[c+1] <= cv[c];
      end
    end

    always_ff @(posedge clk) begin
      czero[c+1] <= czero[c];
      if (!cy[c][CORDIC_W-1]) begin
        cx[c+1] <= cx[c] + dx;
        cy[c+1] <= cy[c] - dy;
        cz[c+1] <= cz[c] + ATAN_TURN[c];
      end else begin
        cx[c+1] <= cx[c] - dx;
        cy[c+1] <= cy[c] + dy;
        cz[c+1] <= cz[c] - ATAN_TURN[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    mq[1]  <= '0;
    lim[1] <= (TEST_W'({nsq, 1'b0}) + TEST_W'(nsq) + TEST_W'(dsq)) << LIM_SHIFT;
  end

  for (genvar c = 1; c < CORDIC_STEPS; c++) begin : g_mod
    if (c <= MOD_W) begin : g_step
      logic [MOD_W-1:0]     q_try;
      logic [MOD_W:0]       t;
      logic [2*MOD_W+1:0]   tt;
      logic [TEST_W-1:0]    test;

      // try the next bit of the root: keep it when 9*(2q-1)^2 fits under the limit
      assign q_try = mq[c] | (MOD_W'(1) << (MOD_W - c));
      assign t     = {q_try, 1'b0} - (MOD_W+1)'(1);
      assign tt    = (2*MOD_W+2)'(t) * (2*MOD_W+2)'(t);
      assign test  = TEST_W'({tt, 3'b000}) + TEST_W'(tt);

      always_ff @(posedge clk) begin
        mq[c+1] <= (test <= lim[c]) ? q_try : mq[c];
      end

      if (c < MOD_W) begin : g_lim
        always_ff @(posedge clk) begin
          lim[c+1] <= lim[c];
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        mq[c+1] <= mq[c];
      end
    end
  end

  assign z_round = cz[CORDIC_STEPS] + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    phase      <= czero[CORDIC_STEPS] ? '0 : z_round[ANGLE_W-1 -: PHASE_W];
    modulation <= mq[CORDIC_STEPS];
    phase_ok   <= mq[CORDIC_STEPS] > threshold;
  end

endmodule

// ===== design/rwpm_checker.sv =====
module rwpm_checker
  import rwpm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic [PIXEL_BITS-1:0] red,
  input logic [PIXEL_BITS-1:0] green,
  input logic [PIXEL_BITS-1:0] blue,
  input logic                  done,
  input logic [PHASE_W-1:0]    phase,
  input logic [MOD_W-1:0]      modulation,
  input logic                  phase_ok
);

  // every beat taken comes out a fixed time later
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##RESULT_LATENCY done)
    else $error("result strobe missing after accepted beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, RESULT_LATENCY))
    else $error("result strobe without a matching beat");

  a_flat_pixel: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && red == green && green == blue)
      |-> ##RESULT_LATENCY (phase == '0 && modulation == '0 && !phase_ok))
    else $error("flat pixel gave nonzero phase or modulation");

  a_zero_mod: assert property (@(posedge clk) disable iff (rst)
    (done && modulation == '0) |-> !phase_ok)
    else $error("valid flag set with zero modulation");

  a_reset_busy: assert property (@(posedge clk)
    rst |=> busy)
    else $error("busy low right after reset");

endmodule

bind rgb_wrapped_phase_modulation rwpm_checker u_rwpm_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rwpm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PIX_MAX        = (1 << PIXEL_BITS) - 1;
  localparam int MOD_MAX        = (1 << MOD_W) - 1;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] red;
    logic [PIXEL_BITS-1:0] green;
    logic [PIXEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [MOD_W-1:0]   modulation;
    logic               valid;
  } fringe_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [PIXEL_BITS-1:0] red = '0;
  logic [PIXEL_BITS-1:0] green = '0;
  logic [PIXEL_BITS-1:0] blue = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [MOD_W-1:0]      cfg_data = '0;
  logic                  done;
  logic [PHASE_W-1:0]    phase;
  logic [MOD_W-1:0]      modulation;
  logic                  phase_ok;

  pixel_t           pixel_q[$];
  fringe_t          fringe_due[$];
  fringe_t          oldest_fringe;
  pixel_t           next_pixel;
  logic [MOD_W-1:0] mod_threshold = '0;
  int               gap = 0;
  int               burst = 0;
  int               roll;
  int               pixels_sent = 0;
  int               results_seen = 0;
  int               valid_seen = 0;
  int               thresholds_set = 0;
  int               mismatches = 0;
  int               idle_cycles = 0;

  rgb_wrapped_phase_modulation DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .phase      (phase),
    .modulation (modulation),
    .phase_ok   (phase_ok)
  );

  always #1 clk = ~clk;

  function automatic logic [PHASE_W-1:0] cordic_phase(longint dn, longint dd);
    longint             x;
    longint             y;
    longint             dx;
    longint             dy;
    logic [ANGLE_W-1:0] z;
    logic [ANGLE_W-1:0] rounded;
    int                 i;
    z = '0;
    if (dn == 0 && dd == 0) return '0;
    x = dd <<< X_SHIFT;
    y = dn * longint'(SQRT3_Q30);
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURN[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURN[i];
      end
    end
    rounded = z + ROUND_HALF;
    return rounded[ANGLE_W-1 -: PHASE_W];
  endfunction

  // largest q with q == 0 or 9*(2q-1)^2 <= 1024*S, saturated
  function automatic logic [MOD_W-1:0] fringe_modulation(longint dn, longint dd);
    longint lim;
    longint t;
    int     lo;
    int     hi;
    int     mid;
    lim = (3 * dn * dn + dd * dd) <<< LIM_SHIFT;
    lo  = 0;
    hi  = MOD_MAX + 1;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t   = longint'(2 * mid - 1);
      if (9 * t * t <= lim) lo = mid;
      else hi = mid - 1;
    end
    if (lo > MOD_MAX) lo = MOD_MAX;
    return lo[MOD_W-1:0];
  endfunction

  function automatic fringe_t predict_fringe(pixel_t p);
    fringe_t f;
    longint  dn;
    longint  dd;
    dn = longint'(p.green) - longint'(p.blue);
    dd = 2 * longint'(p.red) - longint'(p.green) - longint'(p.blue);
    f.phase      = cordic_phase(dn, dd);
    f.modulation = fringe_modulation(dn, dd);
    f.valid      = f.modulation > mod_threshold;
    return f;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    int     kind;
    int     r;
    int     span;
    int     k;
    kind    = $urandom_range(0, 9);
    r       = $urandom_range(0, PIX_MAX);
    p.red   = PIXEL_BITS'(r);
    p.green = PIXEL_BITS'($urandom_range(0, PIX_MAX));
    p.blue  = PIXEL_BITS'($urandom_range(0, PIX_MAX));
    unique case (kind)
      0: p.blue = p.green;
      1: begin
        span    = (r < PIX_MAX - r) ? r : PIX_MAX - r;
        k       = $urandom_range(0, span);
        p.green = PIXEL_BITS'(r + k);
        p.blue  = PIXEL_BITS'(r - k);
        if ($urandom_range(0, 1)) begin
          p.green = PIXEL_BITS'(r - k);
          p.blue  = PIXEL_BITS'(r + k);
        end
      end
      2: begin
        p.green = p.red;
        p.blue  = p.red;
      end
      3: begin
        p.red   = $urandom_range(0, 1) ? PIXEL_BITS'(PIX_MAX) : '0;
        p.green = $urandom_range(0, 1) ? PIXEL_BITS'(PIX_MAX) : '0;
        p.blue  = $urandom_range(0, 1) ? PIXEL_BITS'(PIX_MAX) : '0;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic wait_drained();
    do @(posedge clk); while (pixel_q.size() != 0 || start || fringe_due.size() != 0);
  endtask

  task automatic write_threshold(input logic [MOD_W-1:0] level);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= level;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    mod_threshold = level;
    thresholds_set++;
  endtask

  // driver: hold the beat while busy, otherwise advance
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        fringe_due = {fringe_due, predict_fringe({red, green, blue})};
        pixels_sent++;
      end
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        next_pixel = pixel_q.pop_front();
        red   <= next_pixel.red;
        green <= next_pixel.green;
        blue  <= next_pixel.blue;
        start <= 1'b1;
        if (burst > 0) begin
          burst--;
          gap = 0;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 4) burst = $urandom_range(20, 80);
          if (roll < 55) gap = 0;
          else if (roll < 92) gap = $urandom_range(1, 3);
          else gap = $urandom_range(5, 40);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (phase_ok === 1'b1) valid_seen++;
      if (fringe_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: phase=%0d modulation=%0d valid=%0b",
                   phase, modulation, phase_ok);
        mismatches++;
      end else begin
        oldest_fringe = fringe_due.pop_front();
        if (oldest_fringe.phase !== phase ||
            oldest_fringe.modulation !== modulation ||
            oldest_fringe.valid !== phase_ok) begin
          if (mismatches < 10)
            $display({"mismatch: phase exp %0d got %0d, modulation exp %0d got %0d,",
                      " valid exp %0b got %0b"},
                     oldest_fringe.phase, phase, oldest_fringe.modulation, modulation,
                     oldest_fringe.valid, phase_ok);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int     directed [20][3];
    int     levels [7];
    pixel_t p;
    directed = '{
      '{0, 0, 0}, '{PIX_MAX, PIX_MAX, PIX_MAX}, '{77, 77, 77},
      '{PIX_MAX, 0, 0}, '{0, PIX_MAX, 0}, '{0, 0, PIX_MAX},
      '{0, PIX_MAX, PIX_MAX}, '{PIX_MAX, 0, PIX_MAX}, '{PIX_MAX, PIX_MAX, 0},
      '{PIX_MAX, 0, 1}, '{PIX_MAX, 1, 0}, '{128, PIX_MAX, 1},
      '{128, 1, PIX_MAX}, '{0, 128, 128}, '{0, 127, 128},
      '{0, 128, 127}, '{1, 0, 0}, '{0, 1, 0},
      '{0, 0, 1}, '{PIX_MAX, PIX_MAX - 1, PIX_MAX}
    };
    levels = '{MOD_MAX, 0, 2719, 1, 2048, 0, 0};
    levels[5] = int'($urandom_range(1, 400));
    levels[6] = int'($urandom_range(401, MOD_MAX - 1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[n]) begin
      p.red   = PIXEL_BITS'(directed[n][0]);
      p.green = PIXEL_BITS'(directed[n][1]);
      p.blue  = PIXEL_BITS'(directed[n][2]);
      pixel_q = {pixel_q, p};
    end

    foreach (levels[k]) begin
      write_threshold(MOD_W'(levels[k]));
      repeat (100) pixel_q = {pixel_q, random_pixel()};
      if (k == 3) begin
        wait_drained();
        repeat (20) pixel_q = {pixel_q, random_pixel()};
      end
    end

    wait_drained();
    repeat (RESULT_LATENCY + 10) @(posedge clk);
    mismatches += fringe_due.size();

    $display("covered %0d pixels (%0d results, %0d above threshold)",
             pixels_sent, results_seen, valid_seen);
    $display("threshold programmed %0d times incl. 0 and %0d; %0d errors",
             thresholds_set, MOD_MAX, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
